// ===== src/c3bn_pkg.sv =====
`timescale 1ns / 1ps
package c3bn_pkg;

   localparam int SIZE_W = 9;
   localparam int COEFF_W = 24;
   localparam int SUM_W = 20;
   localparam int DSUM_W = 12;
   localparam int QUO_W = 19;
   localparam int DEN_W = 11;
   localparam int CSR_IDX_W = 3;

   localparam int MAX_WIDTH_DEF = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   localparam logic [SIZE_W-1:0] WIDTH_RST = 9'd256;
   localparam logic [SIZE_W-1:0] HEIGHT_RST = 9'd256;
   localparam logic [COEFF_W-1:0] COEFF_TOP_RST = 24'd65280;
   localparam logic [COEFF_W-1:0] COEFF_MID_RST = 24'd16713215;
   localparam logic [COEFF_W-1:0] COEFF_BOT_RST = 24'd65280;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MID = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOT = 3'd4;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

endpackage

// ===== src/c3bn_if.sv =====
`timescale 1ns / 1ps
interface c3bn_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] pixel_in;
   modport source (output valid, kind, pixel_in, input ready);
   modport sink (input valid, kind, pixel_in, output ready);
endinterface

interface c3bn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_out;
   logic       zero_divisor;
   logic       frame_end;
   modport source (output valid, pixel_out, zero_divisor, frame_end, input ready);
   modport sink (input valid, pixel_out, zero_divisor, frame_end, output ready);
endinterface

interface c3bn_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/c3bn_div.sv =====
`timescale 1ns / 1ps
module c3bn_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [c3bn_pkg::QUO_W-1:0]  dividend,
   input  logic [c3bn_pkg::DEN_W-1:0]  divisor,
   output logic                        done,
   output logic [c3bn_pkg::QUO_W-1:0]  quotient
);
   import c3bn_pkg::*;

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DEN_W:0]   rem_ff, rem_sh;
   logic [QUO_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic             fits;

   assign rem_sh = {rem_ff[DEN_W-1:0], quo_ff[QUO_W-1]};
   assign fits = rem_sh >= {1'b0, den_ff};
   assign done = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= '0;
            quo_ff <= dividend;
            den_ff <= divisor;
         end else if (busy_ff) begin
            rem_ff <= fits ? rem_sh - {1'b0, den_ff} : rem_sh;
            quo_ff <= {quo_ff[QUO_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

// ===== src/conv3x3_border_normalized.sv =====
`timescale 1ns / 1ps
// Normalised 3x3 convolution over a raster stream of 8-bit pixels.
// req_chan carries one item per transfer: a pixel (kind 0) or a drain item
// (kind 1). rsp_chan gives zero or one filtered pixel per item, flagged
// zero_divisor when the in-image coefficients sum to zero and frame_end on
// the last pixel of the frame. csr_chan writes the image size and the three
// kernel rows; write it only while the block is idle.
// One item is worked on at a time. An item that gives no result passes
// through a line store read and a write back; a drain item that is ignored
// is only taken. An item that gives a result also goes through the nine
// taps of the single tap multiply-accumulate one by one, a check of the
// divisor, nineteen steps of the bit-serial divider when the divisor is
// non-zero and the hand-over of the quotient. Results appear one row plus
// one pixel behind input; drain items after the frame flush the rest.
// Reset returns the registers to their defaults and clears the window and
// the counters; the line stores are left as they are.
// rsp_chan has an output register: if the receiver stalls, the result holds
// and the next item is still taken, waiting only when a second result is due.
module conv3x3_border_normalized #(
   parameter int MAX_WIDTH = c3bn_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = c3bn_pkg::MAX_HEIGHT_DEF
) (
   input logic        clock,
   input logic        reset,
   c3bn_req_if.sink   req_chan,
   c3bn_rsp_if.source rsp_chan,
   c3bn_csr_if.sink   csr_chan
);
   import c3bn_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_MAC, S_CHK, S_DIV, S_OUT
   } state_type;

   state_type state_ff;

   logic [SIZE_W-1:0]  width_ff, height_ff;
   logic [COEFF_W-1:0] top_ff, mid_ff, bot_ff;
   logic [SIZE_W-1:0]  w, h;

   logic [SIZE_W-1:0] in_col_ff, in_row_ff, out_col_ff, out_row_ff;
   logic [7:0]        win_ff [3][3];

   logic [15:0]   line_mem [MAX_WIDTH];
   logic [15:0]   line_q_ff;
   logic [AW-1:0] addr_ff, rd_addr;
   logic          we;

   logic [7:0] pix_ff;
   logic       wr_ff, rd_ff, emit_ff;

   logic                     accept, wrap, pix_ph, drop, emit_a, rd_a;
   logic [SIZE_W-1:0]        col_a, row_a, col_n, row_n, col_p;

   logic [1:0]               r_ff, c_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [DSUM_W-1:0] dsum_ff;
   logic [COEFF_W-1:0]       row_sel;
   logic signed [7:0]        cf;
   logic [7:0]               tap;
   logic signed [16:0]       prod;
   logic [SIZE_W:0]          yy1, xx1;
   logic                     tap_ok, last;

   logic                     div_start, div_done;
   logic [QUO_W-1:0]         quo, sum_mag;
   logic [DEN_W-1:0]         den_mag;
   logic                     neg;

   logic [7:0] res_pix_ff;
   logic       res_zero_ff, last_ff;

   logic       rsp_valid_ff, rsp_zero_ff, rsp_end_ff;
   logic [7:0] rsp_pix_ff;

   assign w = (width_ff < SIZE_W'(3)) ? SIZE_W'(3) :
              (32'(width_ff) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : width_ff;
   assign h = (height_ff < SIZE_W'(3)) ? SIZE_W'(3) :
              (32'(height_ff) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : height_ff;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = state_ff == S_IDLE;
   assign accept = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pixel_out = rsp_pix_ff;
   assign rsp_chan.zero_divisor = rsp_zero_ff;
   assign rsp_chan.frame_end = rsp_end_ff;

   always_comb begin
      wrap = (in_row_ff < h) && (in_col_ff >= w);
      col_a = wrap ? '0 : in_col_ff;
      row_a = wrap ? in_row_ff + 1'b1 : in_row_ff;
      pix_ph = row_a < h;
      drop = pix_ph && (req_chan.kind == KIND_DRAIN);
      col_p = col_a + 1'b1;
      if (pix_ph) begin
         rd_a = 1'b1;
         emit_a = (row_a >= SIZE_W'(2)) || ((row_a >= SIZE_W'(1)) && (col_a >= SIZE_W'(1)));
         if (col_p >= w) begin
            col_n = '0;
            row_n = row_a + 1'b1;
         end else begin
            col_n = col_p;
            row_n = row_a;
         end
      end else begin
         rd_a = col_a < w;
         emit_a = 1'b1;
         col_n = (col_a == '1) ? col_a : col_p;
         row_n = row_a;
      end
      rd_addr = AW'(col_a);
   end

   always_comb begin
      case (r_ff)
         2'd0: row_sel = top_ff;
         2'd1: row_sel = mid_ff;
         default: row_sel = bot_ff;
      endcase
      case (c_ff)
         2'd0: cf = $signed(row_sel[7:0]);
         2'd1: cf = $signed(row_sel[15:8]);
         default: cf = $signed(row_sel[23:16]);
      endcase
      tap = win_ff[r_ff][c_ff];
      prod = cf * $signed({1'b0, tap});
      yy1 = {1'b0, out_row_ff} + (SIZE_W+1)'(r_ff);
      xx1 = {1'b0, out_col_ff} + (SIZE_W+1)'(c_ff);
      tap_ok = (yy1 >= (SIZE_W+1)'(1)) && (yy1 <= {1'b0, h}) &&
               (xx1 >= (SIZE_W+1)'(1)) && (xx1 <= {1'b0, w});
      last = (out_row_ff > h - 1'b1) ||
             ((out_row_ff == h - 1'b1) && (out_col_ff >= w - 1'b1));
      sum_mag = sum_ff[SUM_W-1] ? QUO_W'(-sum_ff) : QUO_W'(sum_ff);
      den_mag = dsum_ff[DSUM_W-1] ? DEN_W'(-dsum_ff) : DEN_W'(dsum_ff);
      neg = sum_ff[SUM_W-1] ^ dsum_ff[DSUM_W-1];
      div_start = (state_ff == S_CHK) && (dsum_ff != '0);
      we = (state_ff == S_LOAD) && wr_ff;
   end

   c3bn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (den_mag),
      .done     (div_done),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      line_q_ff <= line_mem[rd_addr];
      if (we) begin
         line_mem[addr_ff] <= {line_q_ff[7:0], pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         top_ff <= COEFF_TOP_RST;
         mid_ff <= COEFF_MID_RST;
         bot_ff <= COEFF_BOT_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_WIDTH: width_ff <= csr_chan.data[SIZE_W-1:0];
            CSR_HEIGHT: height_ff <= csr_chan.data[SIZE_W-1:0];
            CSR_TOP: top_ff <= csr_chan.data;
            CSR_MID: mid_ff <= csr_chan.data;
            CSR_BOT: bot_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (drop) begin
                     in_col_ff <= col_a;
                     in_row_ff <= row_a;
                  end else begin
                     in_col_ff <= col_n;
                     in_row_ff <= row_n;
                     pix_ff <= req_chan.pixel_in;
                     wr_ff <= pix_ph;
                     rd_ff <= rd_a;
                     emit_ff <= emit_a;
                     addr_ff <= rd_addr;
                     state_ff <= S_LOAD;
                  end
               end
            end
            S_LOAD: begin
               for (int i = 0; i < 3; i++) begin
                  win_ff[i][0] <= win_ff[i][1];
                  win_ff[i][1] <= win_ff[i][2];
               end
               win_ff[0][2] <= rd_ff ? line_q_ff[15:8] : 8'd0;
               win_ff[1][2] <= rd_ff ? line_q_ff[7:0] : 8'd0;
               win_ff[2][2] <= wr_ff ? pix_ff : 8'd0;
               r_ff <= '0;
               c_ff <= '0;
               sum_ff <= '0;
               dsum_ff <= '0;
               state_ff <= emit_ff ? S_MAC : S_IDLE;
            end
            S_MAC: begin
               if (tap_ok) begin
                  sum_ff <= sum_ff + SUM_W'(prod);
                  dsum_ff <= dsum_ff + DSUM_W'(cf);
               end
               if (c_ff == 2'd2) begin
                  c_ff <= '0;
                  r_ff <= r_ff + 1'b1;
                  if (r_ff == 2'd2) begin
                     state_ff <= S_CHK;
                  end
               end else begin
                  c_ff <= c_ff + 1'b1;
               end
            end
            S_CHK: begin
               last_ff <= last;
               res_zero_ff <= dsum_ff == '0;
               res_pix_ff <= '0;
               state_ff <= (dsum_ff == '0) ? S_OUT : S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  if (neg) begin
                     res_pix_ff <= '0;
                  end else if (quo > QUO_W'(255)) begin
                     res_pix_ff <= 8'd255;
                  end else begin
                     res_pix_ff <= quo[7:0];
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pix_ff <= res_pix_ff;
                  rsp_zero_ff <= res_zero_ff;
                  rsp_end_ff <= last_ff;
                  if (last_ff) begin
                     in_col_ff <= '0;
                     in_row_ff <= '0;
                     out_col_ff <= '0;
                     out_row_ff <= '0;
                  end else if (out_col_ff + 1'b1 >= w) begin
                     out_col_ff <= '0;
                     out_row_ff <= out_row_ff + 1'b1;
                  end else begin
                     out_col_ff <= out_col_ff + 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
